[sv/gce_pkg.sv]
// Shared types and constants for the gamepad cursor emulator.
// Used by gce_axis and gamepad_cursor_emulator; depends on nothing.
`default_nettype none

package gce_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int TIME_BITS_DEF  = 32;

  // stream and config port widths
  localparam int IN_W       = 96;
  localparam int OUT_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // field widths
  localparam int DEAD_W  = 15;
  localparam int PPS_W   = 12;
  localparam int HOLD_W  = 16;
  localparam int TOAST_W = 16;
  localparam int DIM_W   = 13;
  localparam int AXIS_W  = 16;
  localparam int MOUSE_W = 14;
  localparam int POS_W   = 12;
  localparam int REL_W   = 13;
  localparam int DT_W    = 6;

  // serial multiply-divide lane
  localparam int ADJ_W  = 16;   // |axis| - deadzone, up to 32768
  localparam int MUL_W  = 18;   // speed * dt
  localparam int NUM_W  = 34;   // adj * speed * dt
  localparam int DIV_W  = 25;   // (32767 - deadzone) * 1000
  localparam int STEP_W = 6;

  localparam logic [DEAD_W-1:0]  DEAD_RST  = 15'd6500;
  localparam logic [PPS_W-1:0]   PPS_RST   = 12'd1150;
  localparam logic [HOLD_W-1:0]  HOLD_RST  = 16'd350;
  localparam logic [TOAST_W-1:0] TOAST_RST = 16'd1600;
  localparam logic [DIM_W-1:0]   W_RST     = 13'd1920;
  localparam logic [DIM_W-1:0]   H_RST     = 13'd1080;

  localparam logic [DEAD_W-1:0] DEAD_MAX  = 15'd32766;
  localparam logic [DEAD_W-1:0] AXIS_FULL = 15'd32767;
  localparam int MS_PER_S = 1000;
  localparam int DT_MIN   = 1;
  localparam int DT_MAX   = 50;
  localparam int DT_FIRST = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE = 3'd0,
    REG_SPEED    = 3'd1,
    REG_HOLD     = 3'd2,
    REG_TOAST    = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TOG_NONE = 2'd0,
    TOG_ON   = 2'd1,
    TOG_OFF  = 2'd2
  } toggle_t;

  typedef enum logic [1:0] {
    BEV_NONE    = 2'd0,
    BEV_PRESS   = 2'd1,
    BEV_RELEASE = 2'd2
  } bev_t;

  typedef struct packed {
    logic [ADJ_W-1:0] adj;
    logic [MUL_W-1:0] mult;
    logic [DIV_W-1:0] divisor;
  } axis_op_t;

  typedef struct packed {
    logic             busy;
    logic [NUM_W-1:0] quot;
  } axis_res_t;

endpackage

`default_nettype wire

[sv/gce_axis.sv]
// One axis lane: bit-serial multiply of adj by mult, then restoring divide.
// Depends on gce_pkg.
`default_nettype none

module gce_axis (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  gce_pkg::axis_op_t  op,
  output gce_pkg::axis_res_t res
);
  import gce_pkg::*;

  typedef enum logic [2:0] {
    P_IDLE = 3'b001,
    P_MUL  = 3'b010,
    P_DIV  = 3'b100
  } phase_t;

  phase_t            phase;
  logic [ADJ_W-1:0]  mcand;
  logic [MUL_W-1:0]  mplier;
  logic [DIV_W-1:0]  divisor;
  logic [NUM_W-1:0]  acc;
  logic [DIV_W-1:0]  rem;
  logic [STEP_W-1:0] cnt;

  logic [DIV_W:0]    trial;
  logic              fits;

  always_comb begin
    trial = {rem, acc[NUM_W-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (start) begin
            mcand   <= op.adj;
            mplier  <= op.mult;
            divisor <= op.divisor;
            acc     <= '0;
            cnt     <= STEP_W'(MUL_W - 1);
            phase   <= P_MUL;
          end
        end
        P_MUL: begin
          // msb first: acc = 2*acc + bit*mcand
          acc    <= (acc << 1) + (mplier[MUL_W-1] ? NUM_W'(mcand) : '0);
          mplier <= mplier << 1;
          if (cnt == '0) begin
            rem   <= '0;
            cnt   <= STEP_W'(NUM_W - 1);
            phase <= P_DIV;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        P_DIV: begin
          rem <= fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
          acc <= {acc[NUM_W-2:0], fits};
          if (cnt == '0) begin
            phase <= P_IDLE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  assign res.busy = (phase != P_IDLE);
  assign res.quot = acc;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> phase == P_IDLE)
    else $error("lane started while busy");

  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    phase == P_DIV |-> rem < divisor)
    else $error("partial remainder not below divisor");

  a_mul_to_div: assert property (@(posedge clk) disable iff (rst)
    (phase == P_MUL && cnt == '0) |=> phase == P_DIV)
    else $error("multiply did not hand over to divide");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (phase == P_DIV && cnt == '0) |=> !res.busy)
    else $error("divide did not finish on its last step");

endmodule

`default_nettype wire

[sv/gamepad_cursor_emulator.sv]
// Top level of the gamepad cursor emulator: config registers, tick sequencer,
// output word register. Depends on gce_pkg and gce_axis (two lanes).
`default_nettype none

// One poll tick is taken per input word and gives one output word. A tick that
// moves the cursor (cursor mode on and pad present) goes through the control,
// prepare, run, saturate and move steps: two serial lanes, one per axis, each
// run 18 multiply steps and 34 divide steps of one bit. Any other tick goes
// from the control step straight to the output step. The next tick is taken
// once the current one has been placed in the output register; a full output
// register that is not taken holds the sequencer at its last step.
// Configuration writes are always ready and take effect at once, also mid-tick.
module gamepad_cursor_emulator #(
  parameter int COORD_BITS = gce_pkg::COORD_BITS_DEF,
  parameter int TIME_BITS  = gce_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // s_tdata, lsb up: now_ms[31:0], pad_present, left_click, right_click,
  //   axis_x[15:0], axis_y[15:0], south_button, mouse_x[13:0], mouse_y[13:0]
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [gce_pkg::IN_W-1:0]       s_tdata,
  // m_tdata, lsb up: mode_on, toggle_event[1:0], pos_x[11:0], pos_y[11:0],
  //   motion_valid, rel_x[12:0], rel_y[12:0], motion_held, button_event[1:0],
  //   toast_visible, zero fill[5:0]
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [gce_pkg::OUT_W-1:0]      m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gce_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gce_pkg::*;

  localparam int CW1 = COORD_BITS + 1;
  localparam int CSW = COORD_BITS + 3;
  localparam logic [NUM_W-1:0] STEP_LIM = NUM_W'(1) << COORD_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CTRL = 7'b0000010,
    S_PREP = 7'b0000100,
    S_RUN  = 7'b0001000,
    S_SAT  = 7'b0010000,
    S_MOVE = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic [5:0]       fill;
    logic             toast_visible;
    logic [1:0]       button_event;
    logic             motion_held;
    logic [REL_W-1:0] rel_y;
    logic [REL_W-1:0] rel_x;
    logic             motion_valid;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] pos_x;
    logic [1:0]       toggle_event;
    logic             mode_on;
  } out_word_t;

  // config
  logic [DEAD_W-1:0]  r_dead;
  logic [PPS_W-1:0]   r_pps;
  logic [HOLD_W-1:0]  r_hold;
  logic [TOAST_W-1:0] r_toast;
  logic [DIM_W-1:0]   r_w;
  logic [DIM_W-1:0]   r_h;

  // tick state
  state_t                state;
  logic                  mode;
  logic                  chord_tracking;
  logic                  chord_latched;
  logic [TIME_BITS-1:0]  chord_start;
  logic [TIME_BITS-1:0]  last_move;
  logic [TIME_BITS-1:0]  toast_deadline;
  logic                  click_held;
  logic [COORD_BITS-1:0] cursor_x;
  logic [COORD_BITS-1:0] cursor_y;

  // latched input word
  logic [TIME_BITS-1:0] in_now;
  logic                 in_pad;
  logic                 in_lc;
  logic                 in_rc;
  logic [AXIS_W-1:0]    in_ax;
  logic [AXIS_W-1:0]    in_ay;
  logic                 in_south;
  logic [MOUSE_W-1:0]   in_mx;
  logic [MOUSE_W-1:0]   in_my;

  // per-tick working registers
  toggle_t          tog_r;
  bev_t             bev_r;
  logic             mv_r;
  logic             mheld_r;
  logic [REL_W-1:0] rel_x_r;
  logic [REL_W-1:0] rel_y_r;
  logic [DT_W-1:0]  dt_r;
  logic             act_x;
  logic             act_y;
  logic             neg_x;
  logic             neg_y;
  logic [CW1-1:0]   qs_x;
  logic [CW1-1:0]   qs_y;
  out_word_t        o_word;

  // derived config
  logic [DEAD_W-1:0] dzs;
  logic [DEAD_W-1:0] span;
  logic [DIV_W-1:0]  divisor;
  logic [CW1-1:0]    w_dim;
  logic [CW1-1:0]    h_dim;

  // control step
  logic                 chord_ok;
  logic                 do_toggle;
  logic                 tog_on;
  logic                 run_motion;
  logic [TIME_BITS-1:0] lm_eff;
  logic [TIME_BITS-1:0] elapsed;
  logic [DT_W-1:0]      dt;
  logic                 mouse_out;

  // lane setup
  logic [AXIS_W-1:0] mag_x;
  logic [AXIS_W-1:0] mag_y;
  logic [MUL_W-1:0]  mult;
  logic              lane_start;
  axis_op_t          op_x;
  axis_op_t          op_y;
  axis_res_t         res_x;
  axis_res_t         res_y;

  // move step
  logic signed [CSW-1:0] ox;
  logic signed [CSW-1:0] oy;
  logic signed [CSW-1:0] nx;
  logic signed [CSW-1:0] ny;
  logic signed [CSW-1:0] dif_x;
  logic signed [CSW-1:0] dif_y;

  function automatic logic [CW1-1:0] dim_of(input logic [DIM_W-1:0] v);
    logic [15:0] lim;
    lim = 16'(1) << COORD_BITS;
    if (v == '0) return CW1'(1);
    if (16'(v) > lim) return CW1'(lim);
    return CW1'(v);
  endfunction

  function automatic logic [CW1-1:0] sat_step(input logic [NUM_W-1:0] q);
    if (q == '0) return CW1'(1);
    if (q > STEP_LIM) return CW1'(STEP_LIM);
    return CW1'(q);
  endfunction

  function automatic logic signed [CSW-1:0] new_pos(
    input logic [COORD_BITS-1:0] cur,
    input logic [CW1-1:0]        step,
    input logic                  neg,
    input logic [CW1-1:0]        dim
  );
    logic signed [CSW-1:0] sum;
    logic signed [CSW-1:0] hi;
    sum = neg ? $signed(CSW'(cur)) - $signed(CSW'(step))
              : $signed(CSW'(cur)) + $signed(CSW'(step));
    hi  = $signed(CSW'(dim - 1'b1));
    if (sum < 0) return '0;
    if (sum > hi) return hi;
    return sum;
  endfunction

  always_comb begin
    dzs     = (r_dead > DEAD_MAX) ? DEAD_MAX : r_dead;
    span    = AXIS_FULL - dzs;
    divisor = DIV_W'(span) * DIV_W'(MS_PER_S);
    w_dim   = dim_of(r_w);
    h_dim   = dim_of(r_h);
  end

  always_comb begin
    chord_ok   = in_pad && in_lc && in_rc;
    do_toggle  = chord_ok && chord_tracking && !chord_latched &&
                 ((in_now - chord_start) >= TIME_BITS'(r_hold));
    tog_on     = do_toggle && !mode;
    run_motion = (mode ^ do_toggle) && in_pad;
    lm_eff     = tog_on ? in_now : last_move;
    elapsed    = in_now - lm_eff;
    if (lm_eff == '0) begin
      dt = DT_W'(DT_FIRST);
    end else if (elapsed < TIME_BITS'(DT_MIN)) begin
      dt = DT_W'(DT_MIN);
    end else if (elapsed > TIME_BITS'(DT_MAX)) begin
      dt = DT_W'(DT_MAX);
    end else begin
      dt = DT_W'(elapsed);
    end
    mouse_out = in_mx[MOUSE_W-1] || (16'(in_mx[MOUSE_W-2:0]) >= 16'(w_dim)) ||
                in_my[MOUSE_W-1] || (16'(in_my[MOUSE_W-2:0]) >= 16'(h_dim));
  end

  always_comb begin
    mag_x      = in_ax[AXIS_W-1] ? AXIS_W'(-in_ax) : in_ax;
    mag_y      = in_ay[AXIS_W-1] ? AXIS_W'(-in_ay) : in_ay;
    mult       = MUL_W'(r_pps) * MUL_W'(dt_r);
    lane_start = (state == S_PREP);
    op_x       = '{adj: ADJ_W'(mag_x - AXIS_W'(dzs)), mult: mult, divisor: divisor};
    op_y       = '{adj: ADJ_W'(mag_y - AXIS_W'(dzs)), mult: mult, divisor: divisor};
  end

  always_comb begin
    ox    = $signed(CSW'(cursor_x));
    oy    = $signed(CSW'(cursor_y));
    nx    = new_pos(cursor_x, qs_x, neg_x, w_dim);
    ny    = new_pos(cursor_y, qs_y, neg_y, h_dim);
    dif_x = nx - ox;
    dif_y = ny - oy;
  end

  gce_axis u_lane_x (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .op    (op_x),
    .res   (res_x)
  );

  gce_axis u_lane_y (
    .clk   (clk),
    .rst   (rst),
    .start (lane_start),
    .op    (op_y),
    .res   (res_y)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_dead  <= DEAD_RST;
      r_pps   <= PPS_RST;
      r_hold  <= HOLD_RST;
      r_toast <= TOAST_RST;
      r_w     <= W_RST;
      r_h     <= H_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEADZONE: r_dead  <= cfg_data[DEAD_W-1:0];
        REG_SPEED:    r_pps   <= cfg_data[PPS_W-1:0];
        REG_HOLD:     r_hold  <= cfg_data[HOLD_W-1:0];
        REG_TOAST:    r_toast <= cfg_data[TOAST_W-1:0];
        REG_WIDTH:    r_w     <= cfg_data[DIM_W-1:0];
        REG_HEIGHT:   r_h     <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      mode           <= 1'b0;
      chord_tracking <= 1'b0;
      chord_latched  <= 1'b0;
      chord_start    <= '0;
      last_move      <= '0;
      toast_deadline <= '0;
      click_held     <= 1'b0;
      cursor_x       <= '0;
      cursor_y       <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            in_now   <= TIME_BITS'(s_tdata[31:0]);
            in_pad   <= s_tdata[32];
            in_lc    <= s_tdata[33];
            in_rc    <= s_tdata[34];
            in_ax    <= s_tdata[50:35];
            in_ay    <= s_tdata[66:51];
            in_south <= s_tdata[67];
            in_mx    <= s_tdata[81:68];
            in_my    <= s_tdata[95:82];
            state    <= S_CTRL;
          end
        end
        S_CTRL: begin
          bev_r   <= BEV_NONE;
          tog_r   <= TOG_NONE;
          mv_r    <= 1'b0;
          mheld_r <= 1'b0;
          rel_x_r <= '0;
          rel_y_r <= '0;
          dt_r    <= dt;
          if (!in_pad && click_held) begin
            bev_r      <= BEV_RELEASE;
            click_held <= 1'b0;
          end
          if (!chord_ok) begin
            chord_tracking <= 1'b0;
            chord_latched  <= 1'b0;
          end else if (!chord_tracking) begin
            chord_tracking <= 1'b1;
            chord_start    <= in_now;
          end else if (do_toggle) begin
            chord_latched  <= 1'b1;
            mode           <= !mode;
            toast_deadline <= in_now + TIME_BITS'(r_toast);
            if (tog_on) begin
              tog_r <= TOG_ON;
              if (mouse_out) begin
                cursor_x <= COORD_BITS'(w_dim >> 1);
                cursor_y <= COORD_BITS'(h_dim >> 1);
              end else begin
                cursor_x <= COORD_BITS'(in_mx[MOUSE_W-2:0]);
                cursor_y <= COORD_BITS'(in_my[MOUSE_W-2:0]);
              end
            end else begin
              tog_r <= TOG_OFF;
              if (click_held) begin
                bev_r      <= BEV_RELEASE;
                click_held <= 1'b0;
              end
            end
          end
          if (run_motion) begin
            last_move <= in_now;
            state     <= S_PREP;
          end else begin
            state <= S_FIN;
          end
        end
        S_PREP: begin
          act_x <= mag_x > AXIS_W'(dzs);
          act_y <= mag_y > AXIS_W'(dzs);
          neg_x <= in_ax[AXIS_W-1];
          neg_y <= in_ay[AXIS_W-1];
          state <= S_RUN;
        end
        S_RUN: begin
          if (!res_x.busy && !res_y.busy) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          qs_x  <= act_x ? sat_step(res_x.quot) : '0;
          qs_y  <= act_y ? sat_step(res_y.quot) : '0;
          state <= S_MOVE;
        end
        S_MOVE: begin
          if (act_x || act_y) begin
            cursor_x <= nx[COORD_BITS-1:0];
            cursor_y <= ny[COORD_BITS-1:0];
            rel_x_r  <= REL_W'(dif_x);
            rel_y_r  <= REL_W'(dif_y);
            mv_r     <= 1'b1;
            mheld_r  <= click_held;
          end
          if (in_south != click_held) begin
            bev_r      <= in_south ? BEV_PRESS : BEV_RELEASE;
            click_held <= in_south;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (!m_tvalid || m_tready) begin
            o_word.fill          <= '0;
            o_word.toast_visible <= in_now < toast_deadline;
            o_word.button_event  <= bev_r;
            o_word.motion_held   <= mheld_r;
            o_word.rel_y         <= rel_y_r;
            o_word.rel_x         <= rel_x_r;
            o_word.motion_valid  <= mv_r;
            o_word.pos_y         <= POS_W'(cursor_y);
            o_word.pos_x         <= POS_W'(cursor_x);
            o_word.toggle_event  <= tog_r;
            o_word.mode_on       <= mode;
            m_tvalid             <= 1'b1;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = o_word;

  a_toggle_on_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_word.toggle_event == TOG_ON) |-> o_word.mode_on)
    else $error("turn-on word without cursor mode");

  a_motion_mode: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_word.motion_valid) |-> o_word.mode_on)
    else $error("motion word outside cursor mode");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && mv_r) |-> ({1'b0, cursor_x} < w_dim && {1'b0, cursor_y} < h_dim))
    else $error("cursor beyond window after motion");

  a_lanes_free: assert property (@(posedge clk) disable iff (rst)
    state == S_PREP |-> (!res_x.busy && !res_y.busy))
    else $error("lanes busy at start of motion");

endmodule

`default_nettype wire

[tb/sv/tb_gamepad_cursor_emulator.sv]
`timescale 1ns / 100ps
// Self-checking testbench for gamepad_cursor_emulator: directed poll ticks, then
// random chord, motion and pad-loss sequences under several register settings.
// Depends on gce_pkg and the emulator RTL; expected words come from an in-bench model.
module tb_gamepad_cursor_emulator;
  import gce_pkg::*;

  localparam int SETTLE     = 80;
  localparam int WATCHDOG   = 4000;
  localparam int HOLD_OFF   = 400;
  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic signed [MOUSE_W-1:0] mouse_y;
    logic signed [MOUSE_W-1:0] mouse_x;
    logic                      south;
    logic signed [AXIS_W-1:0]  axis_y;
    logic signed [AXIS_W-1:0]  axis_x;
    logic                      right_click;
    logic                      left_click;
    logic                      pad_present;
    logic [31:0]               now_ms;
  } poll_tick_t;

  typedef struct packed {
    logic [5:0]               fill;
    logic                     toast_visible;
    bev_t                     button_event;
    logic                     motion_held;
    logic signed [REL_W-1:0]  rel_y;
    logic signed [REL_W-1:0]  rel_x;
    logic                     motion_valid;
    logic [POS_W-1:0]         pos_y;
    logic [POS_W-1:0]         pos_x;
    toggle_t                  toggle_event;
    logic                     mode_on;
  } cursor_word_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // model registers and state
  logic [DEAD_W-1:0]  reg_dead;
  logic [PPS_W-1:0]   reg_speed;
  logic [HOLD_W-1:0]  reg_hold;
  logic [TOAST_W-1:0] reg_toast;
  logic [DIM_W-1:0]   reg_width;
  logic [DIM_W-1:0]   reg_height;
  logic               cur_mode;
  logic               chord_armed;
  logic               chord_done;
  logic               click_down;
  logic [31:0]        chord_t0;
  logic [31:0]        last_move_ms;
  logic [31:0]        toast_end_ms;
  logic [POS_W-1:0]   cur_x;
  logic [POS_W-1:0]   cur_y;

  cursor_word_t pending_words[$];
  int           mismatches;
  int           ticks_sent;
  int           words_seen;
  int           toggles;
  int           moves;
  int           clicks;
  int           settings_used;
  logic [31:0]  ms_clock;
  logic         south_state;
  bit           tx_gaps;
  bit           rx_stalls;
  int           rx_hold_req;

  gamepad_cursor_emulator dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint window_span(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    return (v > (1 << POS_W)) ? (1 << POS_W) : longint'(v);
  endfunction

  function automatic longint stick_step(logic signed [AXIS_W-1:0] axis, longint dt);
    longint dz;
    longint mag;
    longint spd;
    longint q;
    dz = reg_dead;
    if (dz > 32766) dz = 32766;
    spd = reg_speed;
    mag = axis;
    if (mag < 0) mag = -mag;
    if (mag <= dz) return 0;
    q = ((mag - dz) * spd * dt) / ((longint'(AXIS_FULL) - dz) * MS_PER_S);
    if (q == 0) q = 1;
    return (axis < 0) ? -q : q;
  endfunction

  function automatic longint clamp_span(longint v, longint hi);
    return (v < 0) ? 0 : ((v > hi) ? hi : v);
  endfunction

  // advances the model by one poll tick and returns the word it should produce
  function automatic cursor_word_t track_cursor(poll_tick_t t);
    cursor_word_t r;
    longint w;
    longint h;
    longint mx;
    longint my;
    longint dx;
    longint dy;
    longint ox;
    longint oy;
    longint nx;
    longint ny;
    logic [31:0] span;
    logic [31:0] dt;
    r = '0;
    w = window_span(reg_width);
    h = window_span(reg_height);
    if (!t.pad_present && click_down) begin
      r.button_event = BEV_RELEASE;
      click_down = 1'b0;
    end
    if (!t.pad_present || !t.left_click || !t.right_click) begin
      chord_armed = 1'b0;
      chord_done = 1'b0;
    end else if (!chord_armed) begin
      chord_armed = 1'b1;
      chord_t0 = t.now_ms;
    end else begin
      span = t.now_ms - chord_t0;
      if (!chord_done && span >= reg_hold) begin
        chord_done = 1'b1;
        cur_mode = !cur_mode;
        toast_end_ms = t.now_ms + reg_toast;
        if (cur_mode) begin
          r.toggle_event = TOG_ON;
          last_move_ms = t.now_ms;
          mx = t.mouse_x;
          my = t.mouse_y;
          if (mx < 0 || mx >= w || my < 0 || my >= h) begin
            cur_x = POS_W'(w / 2);
            cur_y = POS_W'(h / 2);
          end else begin
            cur_x = POS_W'(mx);
            cur_y = POS_W'(my);
          end
        end else begin
          r.toggle_event = TOG_OFF;
          if (click_down) begin
            r.button_event = BEV_RELEASE;
            click_down = 1'b0;
          end
        end
      end
    end
    if (cur_mode && t.pad_present) begin
      span = (last_move_ms == 0) ? DT_FIRST : t.now_ms - last_move_ms;
      dt = (span < DT_MIN) ? DT_MIN : ((span > DT_MAX) ? DT_MAX : span);
      last_move_ms = t.now_ms;
      dx = stick_step(t.axis_x, dt);
      dy = stick_step(t.axis_y, dt);
      if (dx != 0 || dy != 0) begin
        ox = cur_x;
        oy = cur_y;
        nx = clamp_span(ox + dx, w - 1);
        ny = clamp_span(oy + dy, h - 1);
        cur_x = POS_W'(nx);
        cur_y = POS_W'(ny);
        r.rel_x = REL_W'(nx - ox);
        r.rel_y = REL_W'(ny - oy);
        r.motion_valid = 1'b1;
        r.motion_held = click_down;
      end
      if (t.south != click_down) begin
        r.button_event = t.south ? BEV_PRESS : BEV_RELEASE;
        click_down = t.south;
      end
    end
    r.mode_on = cur_mode;
    r.pos_x = cur_x;
    r.pos_y = cur_y;
    r.toast_visible = t.now_ms < toast_end_ms;
    return r;
  endfunction

  function automatic logic signed [AXIS_W-1:0] pick_axis();
    int m;
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      2: begin
        m = reg_dead + $urandom_range(0, 6) - 3;
        if (m < 0) m = 0;
        if (m > 32767) m = 32767;
        return $urandom_range(0, 1) ? m : -m;
      end
      3: return 0;
      4: begin
        m = $urandom_range(0, reg_dead);
        return $urandom_range(0, 1) ? m : -m;
      end
      default: return $urandom_range(0, 1) ? $urandom_range(0, 32767) : -$urandom_range(0, 32768);
    endcase
  endfunction

  function automatic logic signed [MOUSE_W-1:0] pick_mouse(logic [DIM_W-1:0] bound);
    longint s;
    s = window_span(bound);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return s - 1 + $urandom_range(0, 1);
      2: return $urandom_range(0, 1) ? 14'sd0 : -14'sd1;
      default: return $urandom_range(0, s - 1);
    endcase
  endfunction

  function automatic logic [31:0] next_ms();
    case ($urandom_range(0, 19))
      0: ;
      1: ms_clock += $urandom_range(51, 5000);
      default: ms_clock += $urandom_range(1, 50);
    endcase
    return ms_clock;
  endfunction

  function automatic poll_tick_t idle_tick(logic [31:0] now);
    poll_tick_t t;
    t = '0;
    t.now_ms = now;
    t.pad_present = 1'b1;
    return t;
  endfunction

  // pad present, never both stick clicks, button A fairly persistent
  function automatic poll_tick_t live_tick(logic [31:0] now);
    poll_tick_t t;
    t = idle_tick(now);
    t.left_click = $urandom_range(0, 1);
    t.right_click = t.left_click ? 1'b0 : 1'($urandom_range(0, 1));
    t.axis_x = pick_axis();
    t.axis_y = pick_axis();
    if ($urandom_range(0, 3) == 0) south_state = !south_state;
    t.south = south_state;
    t.mouse_x = pick_mouse(reg_width);
    t.mouse_y = pick_mouse(reg_height);
    return t;
  endfunction

  task automatic model_reset();
    reg_dead = DEAD_RST;
    reg_speed = PPS_RST;
    reg_hold = HOLD_RST;
    reg_toast = TOAST_RST;
    reg_width = W_RST;
    reg_height = H_RST;
    cur_mode = 1'b0;
    chord_armed = 1'b0;
    chord_done = 1'b0;
    click_down = 1'b0;
    chord_t0 = '0;
    last_move_ms = '0;
    toast_end_ms = '0;
    cur_x = '0;
    cur_y = '0;
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DEADZONE: reg_dead = value[DEAD_W-1:0];
      REG_SPEED:    reg_speed = value[PPS_W-1:0];
      REG_HOLD:     reg_hold = value[HOLD_W-1:0];
      REG_TOAST:    reg_toast = value[TOAST_W-1:0];
      REG_WIDTH:    reg_width = value[DIM_W-1:0];
      REG_HEIGHT:   reg_height = value[DIM_W-1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(input int dead, input int speed, input int hold,
                                input int toast, input int width, input int height);
    cfg_write(REG_DEADZONE, dead);
    cfg_write(REG_SPEED, speed);
    cfg_write(REG_HOLD, hold);
    cfg_write(REG_TOAST, toast);
    cfg_write(REG_WIDTH, width);
    cfg_write(REG_HEIGHT, height);
    settings_used++;
  endtask

  task automatic send_tick(input poll_tick_t t);
    int gap;
    cursor_word_t w;
    gap = tx_gaps ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= t;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    w = track_cursor(t);
    pending_words.push_back(w);
    ticks_sent++;
    if (w.toggle_event != TOG_NONE) toggles++;
    if (w.motion_valid) moves++;
    if (w.button_event != BEV_NONE) clicks++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // waits until every accepted tick has given its word, then lets the bench go quiet
  task automatic wait_idle();
    drain();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic check_word(input cursor_word_t got);
    cursor_word_t want;
    words_seen++;
    if (pending_words.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_CAP) $error("output word with no poll tick pending");
      return;
    end
    want = pending_words.pop_front();
    check_field("mode_on", want.mode_on, got.mode_on);
    check_field("toggle_event", want.toggle_event, got.toggle_event);
    check_field("pos_x", want.pos_x, got.pos_x);
    check_field("pos_y", want.pos_y, got.pos_y);
    check_field("motion_valid", want.motion_valid, got.motion_valid);
    check_field("rel_x", $signed(want.rel_x), $signed(got.rel_x));
    check_field("rel_y", $signed(want.rel_y), $signed(got.rel_y));
    check_field("motion_held", want.motion_held, got.motion_held);
    check_field("button_event", want.button_event, got.button_event);
    check_field("toast_visible", want.toast_visible, got.toast_visible);
  endtask

  initial begin : word_sink
    int stall;
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_hold_req != 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end else begin
        stall = rx_stalls ? $urandom_range(0, 15) : 0;
      end
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      check_word(cursor_word_t'(m_tdata));
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $error("no word moved for %0d cycles", WATCHDOG);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // reset registers: chord hold, toggles both ways, deadzone edge, clicks, pad loss
  task automatic test_chord_and_motion();
    poll_tick_t t;
    t = idle_tick(100);
    t.pad_present = 1'b0;
    t.left_click = 1'b1;
    t.right_click = 1'b1;
    send_tick(t);
    t = idle_tick(200);
    t.left_click = 1'b1;
    t.right_click = 1'b1;
    t.mouse_x = 500;
    t.mouse_y = 400;
    send_tick(t);
    t.now_ms = 549;
    send_tick(t);
    t.now_ms = 550;
    t.axis_x = 16'sh7FFF;
    t.axis_y = 16'sh8000;
    send_tick(t);
    t.now_ms = 566;
    t.axis_x = 16'sh8000;
    t.axis_y = 16'sh7FFF;
    t.south = 1'b1;
    send_tick(t);
    t = idle_tick(600);
    t.axis_x = DEAD_RST;
    t.axis_y = -(DEAD_RST + 1'b1);
    t.south = 1'b1;
    send_tick(t);
    t = idle_tick(700);
    t.axis_x = 20000;
    send_tick(t);
    t = idle_tick(710);
    t.axis_y = 16'sh7FFF;
    t.south = 1'b1;
    send_tick(t);
    t = idle_tick(720);
    t.pad_present = 1'b0;
    t.south = 1'b1;
    send_tick(t);
    t = idle_tick(730);
    t.left_click = 1'b1;
    t.right_click = 1'b1;
    t.south = 1'b1;
    send_tick(t);
    t.now_ms = 1080;
    send_tick(t);
    t = idle_tick(1090);
    t.axis_x = 16'sh7FFF;
    send_tick(t);
    t = idle_tick(2000);
    t.left_click = 1'b1;
    t.right_click = 1'b1;
    t.mouse_x = -1;
    t.mouse_y = 5;
    send_tick(t);
    t.now_ms = 2350;
    send_tick(t);
  endtask

  // saturating registers, zero hold, toggle at time zero, toast deadline wrap
  task automatic test_register_extremes();
    poll_tick_t t;
    wait_idle();
    apply_settings(32767, 0, 0, 65535, 0, 8191);
    t = idle_tick(0);
    t.pad_present = 1'b0;
    send_tick(t);
    t = idle_tick(0);
    t.left_click = 1'b1;
    t.right_click = 1'b1;
    t.axis_x = 16'sh7FFF;
    t.axis_y = 16'sh8000;
    send_tick(t);
    send_tick(t);
    t.left_click = 1'b0;
    send_tick(t);
    t.left_click = 1'b1;
    send_tick(t);
    send_tick(t);
    t = idle_tick(32'hFFFF_FFF0);
    t.pad_present = 1'b0;
    send_tick(t);
    t.pad_present = 1'b1;
    t.left_click = 1'b1;
    t.right_click = 1'b1;
    send_tick(t);
    send_tick(t);
  endtask

  task automatic play_random(input int count);
    int sent;
    int n;
    int k;
    poll_tick_t t;
    logic [31:0] t0;
    sent = 0;
    while (sent < count) begin
      k = $urandom_range(0, 99);
      if (k < 8) begin
        t = poll_tick_t'({$urandom(), $urandom(), $urandom()});
        send_tick(t);
        sent++;
      end else if (k < 30) begin
        // chord held long enough to toggle, then let go
        t0 = next_ms();
        t = live_tick(t0);
        t.left_click = 1'b1;
        t.right_click = 1'b1;
        send_tick(t);
        sent++;
        if (reg_hold > 1 && $urandom_range(0, 2) == 0) begin
          t.now_ms = t0 + $urandom_range(1, reg_hold - 1);
          send_tick(t);
          sent++;
        end
        ms_clock = t0 + reg_hold + $urandom_range(0, 40);
        t = live_tick(ms_clock);
        t.left_click = 1'b1;
        t.right_click = 1'b1;
        send_tick(t);
        sent++;
        if ($urandom_range(0, 1) != 0) begin
          t = live_tick(next_ms());
          t.left_click = 1'b1;
          t.right_click = 1'b1;
          send_tick(t);
          sent++;
        end
        send_tick(live_tick(next_ms()));
        sent++;
      end else if (k < 36) begin
        t = live_tick(next_ms());
        t.pad_present = 1'b0;
        t.left_click = $urandom_range(0, 1);
        t.right_click = $urandom_range(0, 1);
        send_tick(t);
        sent++;
      end else begin
        n = $urandom_range(1, 12);
        repeat (n) send_tick(live_tick(next_ms()));
        sent += n;
      end
    end
  endtask

  task automatic test_random_play();
    for (int p = 0; p < 8; p++) begin
      wait_idle();
      case (p)
        0: apply_settings(0, 4095, 0, 0, 4096, 4096);
        1: apply_settings($urandom_range(0, 12000), $urandom_range(0, 4095),
                          $urandom_range(0, 800), $urandom_range(0, 5000), 64, 48);
        2: apply_settings(32767, 0, 65535, 65535, 1, 1);
        3: apply_settings($urandom_range(0, 32767), $urandom_range(0, 4095), HOLD_RST,
                          TOAST_RST, 0, 8191);
        default: apply_settings($urandom_range(0, 3) == 0 ? $urandom_range(0, 32767)
                                                          : $urandom_range(0, 12000),
                                $urandom_range(0, 4095), $urandom_range(0, 800),
                                $urandom_range(0, 65535),
                                $urandom_range(0, 7) == 0 ? $urandom_range(0, 8191)
                                                          : $urandom_range(1, 4096),
                                $urandom_range(1, 4096));
      endcase
      if (p % 4 == 3)
        ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 4000);
      else
        ms_clock = $urandom_range(1, 1 << 20);
      tx_gaps = (p % 3 != 1);
      rx_stalls = (p % 3 != 2);
      play_random(240);
    end
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
  endtask

  // sink stops for a long stretch while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    tx_gaps = 1'b0;
    rx_hold_req = HOLD_OFF;
    repeat (40) send_tick(live_tick(next_ms()));
    tx_gaps = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (20) send_tick(live_tick(next_ms()));
    drain();
    repeat (20) send_tick(live_tick(next_ms()));
  endtask

  initial begin : stimulus
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_DEADZONE;
    cfg_data = '0;
    mismatches = 0;
    ticks_sent = 0;
    words_seen = 0;
    toggles = 0;
    moves = 0;
    clicks = 0;
    settings_used = 0;
    ms_clock = '0;
    south_state = 1'b0;
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    rx_hold_req = 0;
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_chord_and_motion();
    test_register_extremes();
    test_random_play();
    test_backpressure();
    test_sender_pause();
    wait_idle();
    $display("Sent %0d poll ticks under %0d register settings, checked %0d words:",
             ticks_sent, settings_used + 1, words_seen);
    $display("  %0d mode toggles, %0d cursor moves, %0d click events", toggles, moves, clicks);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
